// ===== rtl/dltq_pkg.sv =====
// Shared constants, command/status structs and state encoding of the timeout queue.
package dltq_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DELTA_W     = 16;
    localparam int ID_W        = 8;
    localparam int ARG_W       = 32;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_WALK  = 6'b000010,
        S_OVF       = 6'b000100,
        S_TICK_FIND = 6'b001000,
        S_FIRE      = 6'b010000,
        S_SPARE     = 6'b100000
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic walk;
        logic ptr_inc;
        logic dec;
        logic place;
        logic emit_fire;
        logic emit_ovf;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic blocked;
        logic full;
        logic ptr_at_count;
        logic cur_le;
        logic cur_nz;
        logic head_zero;
        logic count_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/dltq_if.sv =====
// Request and response channel interfaces of the timeout queue.
interface dltq_in_if import dltq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic               blocked;
    logic [DELTA_W-1:0] delay_ticks;
    logic [ID_W-1:0]    callback_id;
    logic [ARG_W-1:0]   callback_arg;

    modport source (output valid, kind, blocked, delay_ticks, callback_id, callback_arg,
                    input ready);
    modport sink   (input valid, kind, blocked, delay_ticks, callback_id, callback_arg,
                    output ready);
endinterface

interface dltq_out_if import dltq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  fired_id;
    logic [ARG_W-1:0] fired_arg;
    logic             overflow;
    logic             last;

    modport source (output valid, fired_id, fired_arg, overflow, last, input ready);
    modport sink   (input valid, fired_id, fired_arg, overflow, last, output ready);
endinterface

// ===== rtl/dltq_ctrl.sv =====
// Sequencer that walks the delta list for inserts, ticks and firing runs.
module dltq_ctrl import dltq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_kind) begin
                        n_state = i_status.full ? S_OVF : S_INS_WALK;
                    end else begin
                        n_state = S_TICK_FIND;
                    end
                end
            end
            S_OVF: begin
                if (i_status.out_free) begin
                    o_cmd.emit_ovf = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_INS_WALK: begin
                // skip entries that expire no later than the new one
                if (!i_status.ptr_at_count && i_status.cur_le) begin
                    o_cmd.walk = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TICK_FIND: begin
                if (i_status.ptr_at_count) begin
                    n_state = i_status.blocked ? S_IDLE : S_FIRE;
                end else if (i_status.cur_nz) begin
                    o_cmd.dec = 1'b1;
                    n_state   = i_status.blocked ? S_IDLE : S_FIRE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_FIRE: begin
                if (i_status.count_zero || !i_status.head_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit_fire = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dltq_datapath.sv =====
// Delta-list table, walk pointer, remaining delay and output register.
module dltq_datapath import dltq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    dltq_in_if.sink    i_req,
    dltq_out_if.source o_rsp
);

    logic [DELTA_W-1:0] r_delta [TABLE_DEPTH];
    logic [ID_W-1:0]    r_id    [TABLE_DEPTH];
    logic [ARG_W-1:0]   r_arg   [TABLE_DEPTH];
    logic [DELTA_W-1:0] n_delta [TABLE_DEPTH];
    logic [ID_W-1:0]    n_id    [TABLE_DEPTH];
    logic [ARG_W-1:0]   n_arg   [TABLE_DEPTH];

    logic [IDX_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [DELTA_W-1:0] r_rem, n_rem;
    logic               r_blk, n_blk;
    logic [ID_W-1:0]    r_new_id, n_new_id;
    logic [ARG_W-1:0]   r_new_arg, n_new_arg;

    logic               r_out_valid, n_out_valid;
    logic [ID_W-1:0]    r_out_id, n_out_id;
    logic [ARG_W-1:0]   r_out_arg, n_out_arg;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;

    logic [DELTA_W-1:0] cur_delta;
    logic               out_free;
    logic               head_last;

    assign cur_delta = r_delta[r_ptr];
    assign out_free  = !r_out_valid || o_rsp.ready;
    // head is the final one of the run when nothing follows or the follower is still pending
    assign head_last = (r_count == IDX_W'(1)) || (r_delta[1] != '0);

    assign i_req.ready = i_cmd.in_ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.fired_id  = r_out_id;
    assign o_rsp.fired_arg = r_out_arg;
    assign o_rsp.overflow  = r_out_ovf;
    assign o_rsp.last      = r_out_last;

    always_comb begin
        o_status.in_valid     = i_req.valid;
        o_status.in_kind      = i_req.kind;
        o_status.blocked      = r_blk;
        o_status.full         = (r_count >= IDX_W'(TABLE_DEPTH - 1));
        o_status.ptr_at_count = (r_ptr == r_count);
        o_status.cur_le       = (cur_delta <= r_rem);
        o_status.cur_nz       = (cur_delta != '0);
        o_status.head_zero    = (r_delta[0] == '0);
        o_status.count_zero   = (r_count == '0);
        o_status.out_free     = out_free;
    end

    always_comb begin
        n_delta     = r_delta;
        n_id        = r_id;
        n_arg       = r_arg;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_rem       = r_rem;
        n_blk       = r_blk;
        n_new_id    = r_new_id;
        n_new_arg   = r_new_arg;
        n_out_valid = r_out_valid;
        n_out_id    = r_out_id;
        n_out_arg   = r_out_arg;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_ptr     = '0;
            n_rem     = i_req.delay_ticks;
            n_blk     = i_req.blocked;
            n_new_id  = i_req.callback_id;
            n_new_arg = i_req.callback_arg;
        end

        if (i_cmd.walk) begin
            n_rem = r_rem - cur_delta;
            n_ptr = r_ptr + IDX_W'(1);
        end

        if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + IDX_W'(1);
        end

        if (i_cmd.dec) begin
            n_delta[r_ptr] = cur_delta - DELTA_W'(1);
        end

        if (i_cmd.place) begin
            // open a slot at the pointer; the follower keeps only what remains
            for (int i = 1; i < TABLE_DEPTH; i++) begin
                if (IDX_W'(i) > r_ptr && IDX_W'(i) <= r_count) begin
                    n_delta[i] = (IDX_W'(i - 1) == r_ptr) ? cur_delta - r_rem
                                                            : r_delta[i-1];
                    n_id[i]    = r_id[i-1];
                    n_arg[i]   = r_arg[i-1];
                end
            end
            n_delta[r_ptr] = r_rem;
            n_id[r_ptr]    = r_new_id;
            n_arg[r_ptr]   = r_new_arg;
            n_count        = r_count + IDX_W'(1);
        end

        if (i_cmd.emit_fire) begin
            n_out_valid = 1'b1;
            n_out_id    = r_id[0];
            n_out_arg   = r_arg[0];
            n_out_ovf   = 1'b0;
            n_out_last  = head_last;
            // drop the head and advance the rest by one slot
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                n_delta[i] = r_delta[i+1];
                n_id[i]    = r_id[i+1];
                n_arg[i]   = r_arg[i+1];
            end
            n_count = r_count - IDX_W'(1);
        end

        if (i_cmd.emit_ovf) begin
            n_out_valid = 1'b1;
            n_out_id    = '0;
            n_out_arg   = '0;
            n_out_ovf   = 1'b1;
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_delta[i] <= '0;
            end
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_delta     <= n_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_arg      <= n_arg;
        r_ptr      <= n_ptr;
        r_rem      <= n_rem;
        r_blk      <= n_blk;
        r_new_id   <= n_new_id;
        r_new_arg  <= n_new_arg;
        r_out_id   <= n_out_id;
        r_out_arg  <= n_out_arg;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(TABLE_DEPTH - 1))
        else $error("entry count above capacity");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_fire || i_cmd.emit_ovf) |-> out_free && !(i_cmd.emit_fire && i_cmd.emit_ovf))
        else $error("result loaded over a pending one");

    a_fire_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_fire |-> r_count != '0 && r_delta[0] == '0)
        else $error("fired an entry that has not expired");

    a_place_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |=> r_count == $past(r_count) + IDX_W'(1))
        else $error("insert did not grow the table");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> r_out_id == '0 && r_out_arg == '0 && r_out_last)
        else $error("overflow result carries payload");

endmodule

// ===== rtl/delta_list_timeout_queue.sv =====
// An insert is accepted, skips each entry that expires no later than it and is then placed;
// an insert into a full table instead waits for a free output and sends an overflow result.
// A tick is accepted, scans past leading zero entries and decrements the first nonzero one,
// then, unless blocked, fires each expired request. One request is handled at a time.
// A firing run sends one request per cycle while the output is taken without stall.
// Reset (synchronous, active low) empties the table and clears all deltas; no clearing pass.
module delta_list_timeout_queue import dltq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_in_if.sink    i_req,
    dltq_out_if.source o_rsp
);

    t_cmd    cmd;
    t_status status;

    dltq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dltq_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_req    (i_req),
        .o_rsp    (o_rsp)
    );

endmodule

// ===== bench/delta_list_timeout_queue_test.sv =====
// Self-checking testbench of the delta-list timeout queue: directed table, then random requests.
module delta_list_timeout_queue_test import dltq_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam int DIR_N     = 25;
    localparam int RAND_N    = 300;
    localparam int PHASE_N   = 100;
    localparam int BURST_N   = 20;
    localparam int FAR_TICKS = 400;
    localparam int FAR_MAX   = 5;
    localparam int END_WAIT  = 2 * TABLE_DEPTH + 16;

    typedef struct packed {
        logic               kind;
        logic               blocked;
        logic [DELTA_W-1:0] delay;
        logic [ID_W-1:0]    id;
        logic [ARG_W-1:0]   arg;
    } timer_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [ARG_W-1:0] arg;
        logic             ovf;
        logic             last;
    } timer_rsp_t;

    typedef struct packed {
        timer_req_t req;
        logic       fixed;    // expectation typed in the row, not predicted
        logic       has_rsp;
        timer_rsp_t rsp;
    } dir_row_t;

    localparam timer_rsp_t NO_RSP  = '0;
    localparam timer_rsp_t OVF_RSP = '{8'h00, 32'h0000_0000, 1'b1, 1'b1};

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // tick on an empty table does nothing
        '{'{KIND_TICK,   1'b0, 16'd0,     8'h00, 32'h0000_0000}, 1'b1, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd0,     8'hFF, 32'hFFFF_FFFF}, 1'b0, 1'b0, NO_RSP},
        // only a zero delta held: nothing to decrement, fire it
        '{'{KIND_TICK,   1'b0, 16'd0,     8'h00, 32'h0000_0000}, 1'b1, 1'b1,
          '{8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1}},
        '{'{KIND_INSERT, 1'b0, 16'd65535, 8'h00, 32'h0000_0000}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd2,     8'h01, 32'h0000_0001}, 1'b0, 1'b0, NO_RSP},
        // equal expiry goes behind the older entry
        '{'{KIND_INSERT, 1'b0, 16'd2,     8'h02, 32'h8000_0000}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd0,     8'h03, 32'h1234_5678}, 1'b0, 1'b0, NO_RSP},
        // blocked: decrement, hold the expired head
        '{'{KIND_TICK,   1'b1, 16'd0,     8'h00, 32'h0000_0000}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_TICK,   1'b0, 16'd0,     8'h00, 32'h0000_0000}, 1'b0, 1'b0, NO_RSP},
        // fill the table up to its capacity
        '{'{KIND_INSERT, 1'b0, 16'd5,     8'h10, 32'h0000_0010}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd9,     8'h11, 32'h5555_5555}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd2,     8'h12, 32'hAAAA_AAAA}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd2,     8'h13, 32'h0000_0013}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd40,    8'h14, 32'h0000_0014}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd7,     8'h15, 32'h0000_0015}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd100,   8'h16, 32'h0000_0016}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd200,   8'h17, 32'h0000_0017}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd3,     8'h18, 32'h0000_0018}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd60000, 8'h19, 32'h0000_0019}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd12,    8'h1A, 32'h0000_001A}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd5,     8'h1B, 32'h0000_001B}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd8,     8'h1C, 32'h0000_001C}, 1'b0, 1'b0, NO_RSP},
        '{'{KIND_INSERT, 1'b0, 16'd30,    8'h1D, 32'h0000_001D}, 1'b0, 1'b0, NO_RSP},
        // table full: reject
        '{'{KIND_INSERT, 1'b0, 16'd7,     8'hEE, 32'hDEAD_BEEF}, 1'b1, 1'b1, OVF_RSP},
        // tick that fires nothing
        '{'{KIND_TICK,   1'b0, 16'd0,     8'h00, 32'h0000_0000}, 1'b0, 1'b0, NO_RSP}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dltq_in_if  req_ch();
    dltq_out_if rsp_ch();

    delta_list_timeout_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow of the timeout table.
    logic [DELTA_W-1:0] tq_delta [TABLE_DEPTH];
    logic [ID_W-1:0]    tq_id    [TABLE_DEPTH];
    logic [ARG_W-1:0]   tq_arg   [TABLE_DEPTH];
    int                 tq_count;
    int                 peak_fill;

    timer_rsp_t expected_fires[$];

    int send_idle_pct  = 22;
    int recv_stall_pct = 46;
    int err_cnt        = 0;
    int n_req          = 0;
    int n_fired        = 0;
    int n_ovf          = 0;

    always #5 i_clk = ~i_clk;

    // Advance the shadow table by one request; queue its results when keep is set.
    function automatic void predict(timer_req_t r, bit keep);
        logic [DELTA_W-1:0] rem;
        int                 pos;
        int                 nfire;
        bit                 done;
        if (r.kind == KIND_INSERT) begin
            if (tq_count >= TABLE_DEPTH - 1) begin
                if (keep) expected_fires.push_back(OVF_RSP);
            end else begin
                rem = r.delay;
                pos = 0;
                while (pos < tq_count && tq_delta[pos] <= rem) begin
                    rem = rem - tq_delta[pos];
                    pos++;
                end
                if (pos < tq_count) tq_delta[pos] = tq_delta[pos] - rem;
                for (int i = tq_count; i > pos; i--) begin
                    tq_delta[i] = tq_delta[i-1];
                    tq_id[i]    = tq_id[i-1];
                    tq_arg[i]   = tq_arg[i-1];
                end
                tq_delta[pos] = rem;
                tq_id[pos]    = r.id;
                tq_arg[pos]   = r.arg;
                tq_count++;
                if (tq_count > peak_fill) peak_fill = tq_count;
            end
        end else if (tq_count != 0) begin
            done = 1'b0;
            for (int i = 0; i < tq_count; i++) begin
                if (!done && tq_delta[i] != 0) begin
                    tq_delta[i] = tq_delta[i] - 1'b1;
                    done = 1'b1;
                end
            end
            if (!r.blocked) begin
                nfire = 0;
                while (nfire < tq_count && tq_delta[nfire] == 0) nfire++;
                for (int k = 0; k < nfire; k++) begin
                    if (keep) begin
                        expected_fires.push_back(timer_rsp_t'{tq_id[k], tq_arg[k], 1'b0,
                                                              (k == nfire - 1)});
                    end
                end
                for (int i = nfire; i < tq_count; i++) begin
                    tq_delta[i-nfire] = tq_delta[i];
                    tq_id[i-nfire]    = tq_id[i];
                    tq_arg[i-nfire]   = tq_arg[i];
                end
                tq_count = tq_count - nfire;
            end
        end
    endfunction

    // Entries whose absolute expiry lies far beyond the run.
    function automatic int far_entries();
        int sum;
        int cnt;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < tq_count; i++) begin
            sum = sum + tq_delta[i];
            if (sum > FAR_TICKS) cnt++;
        end
        return cnt;
    endfunction

    task automatic send_req(timer_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= r.kind;
        req_ch.blocked      <= r.blocked;
        req_ch.delay_ticks  <= r.delay;
        req_ch.callback_id  <= r.id;
        req_ch.callback_arg <= r.arg;
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        n_req++;
    endtask

    // Drop valid and hold off until every pending result has come back.
    task automatic drain_wait();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_fires.size() != 0);
    endtask

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        timer_rsp_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_ch.overflow) n_ovf++;
            else n_fired++;
            if (expected_fires.size() == 0) begin
                $error("unexpected result: fired_id %0h fired_arg %0h overflow %0b last %0b",
                       rsp_ch.fired_id, rsp_ch.fired_arg, rsp_ch.overflow, rsp_ch.last);
                err_cnt++;
            end else begin
                want = expected_fires.pop_front();
                if (rsp_ch.fired_id !== want.id) begin
                    $error("fired_id: expected %0h, got %0h", want.id, rsp_ch.fired_id);
                    err_cnt++;
                end
                if (rsp_ch.fired_arg !== want.arg) begin
                    $error("fired_arg: expected %0h, got %0h", want.arg, rsp_ch.fired_arg);
                    err_cnt++;
                end
                if (rsp_ch.overflow !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, rsp_ch.overflow);
                    err_cnt++;
                end
                if (rsp_ch.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        timer_req_t r;
        int         ins_pct;
        int         pick;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.kind         <= KIND_TICK;
        req_ch.blocked      <= 1'b0;
        req_ch.delay_ticks  <= '0;
        req_ch.callback_id  <= '0;
        req_ch.callback_arg <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++) tq_delta[i] = '0;
        tq_count  = 0;
        peak_fill = 0;
        ins_pct   = 50;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            send_req(DIR_ROWS[i].req);
            predict(DIR_ROWS[i].req, !DIR_ROWS[i].fixed);
            if (DIR_ROWS[i].fixed && DIR_ROWS[i].has_rsp)
                expected_fires.push_back(DIR_ROWS[i].rsp);
        end

        for (int i = 0; i < RAND_N; i++) begin
            if (i % PHASE_N == 0) begin
                drain_wait();
                case (i / PHASE_N)
                    0: begin
                        send_idle_pct  = 22;
                        recv_stall_pct = 46;
                    end
                    1: begin
                        send_idle_pct  = 46;
                        recv_stall_pct = 22;
                    end
                    default: begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                endcase
            end
            // vary the insert share so the table both fills to overflow and drains
            if (i % BURST_N == 0) begin
                case ($urandom_range(2))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    default: ins_pct = 75;
                endcase
            end
            r.kind    = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_TICK;
            r.blocked = ($urandom_range(99) < 15);
            r.id      = ID_W'($urandom);
            r.arg     = $urandom;
            pick      = $urandom_range(99);
            if (pick < 60)
                r.delay = DELTA_W'($urandom_range(6));
            else if (pick < 85 || far_entries() >= FAR_MAX)
                r.delay = DELTA_W'($urandom_range(40));
            else if (pick < 95)
                r.delay = DELTA_W'($urandom);
            else
                r.delay = 16'hFFFF;
            send_req(r);
            predict(r, 1'b1);
        end

        drain_wait();
        repeat (END_WAIT) @(posedge i_clk);

        $display("run covered %0d requests (%0d directed), %0d fired entries, %0d overflows",
                 n_req, DIR_N, n_fired, n_ovf);
        $display("peak table fill %0d of %0d usable slots, three idle/stall patterns",
                 peak_fill, TABLE_DEPTH - 1);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dltq_pkg.sv
rtl/dltq_if.sv
rtl/dltq_ctrl.sv
rtl/dltq_datapath.sv
rtl/delta_list_timeout_queue.sv
bench/delta_list_timeout_queue_test.sv
